// File: hdl/qbq_pkg.sv
// ----------------------------------------------------------------------------
// qbq_pkg: shared types and constants of the quantized biquad core
// Lane count, fixed-point widths, register indexes, reset values and the
// lane sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package qbq_pkg;

  localparam int LANES            = 6;
  localparam int FIRST_GROUP_LAST = 2;

  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 32;
  localparam int STEP_W   = 16;
  localparam int Y_W      = 48;
  localparam int ACC_W    = 53;
  localparam int PROD_W   = 65;
  localparam int FSUM_W   = 81;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_BITS = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [Y_W-1:0]      y_t;
  typedef logic        [STEP_W-1:0]   step_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  typedef struct packed {
    logic    done;
    sample_t result;
  } lane_out_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MAC,
    L_SAT,
    L_DIV,
    L_DONE
  } lane_state_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_B0          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FIRST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SECOND = 3'd6;

  // Product terms, in the order the lane multiplier produces them.
  localparam logic [2:0] TERM_B0    = 3'd0;
  localparam logic [2:0] TERM_B1    = 3'd1;
  localparam logic [2:0] TERM_B2    = 3'd2;
  localparam logic [2:0] TERM_A1_HI = 3'd3;
  localparam logic [2:0] TERM_A1_LO = 3'd4;
  localparam logic [2:0] TERM_A2_HI = 3'd5;
  localparam logic [2:0] TERM_A2_LO = 3'd6;
  localparam logic [2:0] MAC_LAST   = 3'd7;
  localparam logic [2:0] DIV_LAST   = 3'd7;

  localparam coef_t RST_B0 = 32'sd116071;
  localparam coef_t RST_B1 = 32'sd232036;
  localparam coef_t RST_B2 = 32'sd116071;
  localparam coef_t RST_A1 = -32'sd2115700890;
  localparam coef_t RST_A2 = 32'sd1042388563;
  localparam step_t RST_STEP_FIRST  = 16'd1311;
  localparam step_t RST_STEP_SECOND = 16'd2621;

  localparam y_t Y_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam y_t Y_MIN = 48'sh8000_0000_0000;

endpackage

`default_nettype wire

// File: hdl/qbq_lane.sv
// ----------------------------------------------------------------------------
// qbq_lane: one biquad lane
// Runs one Direct Form I section on a shared multiplier, one product per
// cycle, saturates the sum to Q16.32 and quantizes it with a radix-16
// restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module qbq_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               ack,
  input  qbq_pkg::sample_t   x_in,
  input  qbq_pkg::coef_set_t coefs,
  input  qbq_pkg::step_t     step,
  output qbq_pkg::lane_out_t status
);
  import qbq_pkg::*;

  lane_state_t state, state_next;
  logic [2:0] cnt;
  logic [2:0] tag;
  logic       pvalid;

  sample_t x0, x1, x2;
  y_t      y1, y2;

  coef_t                    op_a;
  logic signed [SAMPLE_W:0] op_b;
  logic signed [PROD_W-1:0] prod, fb;
  logic signed [FSUM_W-1:0] fsum;
  logic signed [ACC_W-1:0]  acc, acc_next;

  logic            sat_ovf;
  y_t              y_sat;
  logic [Y_W:0]    y_ext, y_abs;

  logic                neg;
  logic [SAMPLE_W-1:0] mag, dvd, dvd_next, q_mag;
  step_t               dsr, rem, rem_next;

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE: if (start) state_next = L_MAC;
      L_MAC:  if (cnt == MAC_LAST) state_next = L_SAT;
      L_SAT:  state_next = L_DIV;
      L_DIV:  if (cnt == DIV_LAST) state_next = L_DONE;
      L_DONE: if (ack) state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  always_comb begin
    q_mag         = mag - {{(SAMPLE_W-STEP_W){1'b0}}, rem};
    status.done   = (state == L_DONE);
    status.result = neg ? -$signed(q_mag) : $signed(q_mag);
  end

  // Multiplier operands. The 48-bit outputs are split into a signed high
  // half and an unsigned low half so that each product stays 32 by 33 bits.
  always_comb begin
    case (cnt)
      TERM_B0: begin
        op_a = coefs.b0;
        op_b = {x0[SAMPLE_W-1], x0};
      end
      TERM_B1: begin
        op_a = coefs.b1;
        op_b = {x1[SAMPLE_W-1], x1};
      end
      TERM_B2: begin
        op_a = coefs.b2;
        op_b = {x2[SAMPLE_W-1], x2};
      end
      TERM_A1_HI: begin
        op_a = coefs.a1;
        op_b = {y1[Y_W-1], y1[Y_W-1:16]};
      end
      TERM_A1_LO: begin
        op_a = coefs.a1;
        op_b = {17'd0, y1[15:0]};
      end
      TERM_A2_HI: begin
        op_a = coefs.a2;
        op_b = {y2[Y_W-1], y2[Y_W-1:16]};
      end
      default: begin
        op_a = coefs.a2;
        op_b = {17'd0, y2[15:0]};
      end
    endcase
  end

  // Accumulation. Feed-forward products are floored by 2^14 each; a feedback
  // term joins its two halves before it is floored by 2^30.
  always_comb begin
    fsum     = $signed({fb, 16'h0000}) + $signed({{16{prod[PROD_W-1]}}, prod});
    acc_next = acc;
    if (pvalid) begin
      case (tag) inside
        TERM_B0, TERM_B1, TERM_B2:
          acc_next = acc + ACC_W'($signed(prod[PROD_W-1:14]));
        TERM_A1_LO, TERM_A2_LO:
          acc_next = acc - ACC_W'($signed(fsum[FSUM_W-1:30]));
        default: acc_next = acc;
      endcase
    end
  end

  // Saturation to Q16.32 and magnitude for the quantizer.
  always_comb begin
    sat_ovf = !((&acc[ACC_W-1:Y_W-1]) || !(|acc[ACC_W-1:Y_W-1]));
    if (sat_ovf) y_sat = acc[ACC_W-1] ? Y_MIN : Y_MAX;
    else         y_sat = acc[Y_W-1:0];
    y_ext = {y_sat[Y_W-1], y_sat};
    y_abs = y_sat[Y_W-1] ? (~y_ext + 1'b1) : y_ext;
  end

  // Restoring division, DIV_BITS quotient bits per cycle. Only the
  // remainder is kept: the quantized magnitude is dividend minus remainder.
  always_comb begin
    logic [STEP_W:0]     r17;
    logic [STEP_W-1:0]   r;
    logic [SAMPLE_W-1:0] d;
    r = rem;
    d = dvd;
    for (int k = 0; k < DIV_BITS; k++) begin
      r17 = {r, d[SAMPLE_W-1]};
      d   = {d[SAMPLE_W-2:0], 1'b0};
      if (r17 >= {1'b0, dsr}) r17 = r17 - {1'b0, dsr};
      r = r17[STEP_W-1:0];
    end
    rem_next = r;
    dvd_next = d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= L_IDLE;
      cnt    <= '0;
      pvalid <= 1'b0;
      x1     <= '0;
      x2     <= '0;
      y1     <= '0;
      y2     <= '0;
    end else begin
      state <= state_next;
      case (state)
        L_IDLE: begin
          cnt    <= '0;
          pvalid <= 1'b0;
        end
        L_MAC: begin
          cnt    <= cnt + 1'b1;
          pvalid <= (cnt != MAC_LAST);
        end
        L_SAT: begin
          cnt <= '0;
          x2  <= x1;
          x1  <= x0;
          y2  <= y1;
          y1  <= y_sat;
        end
        L_DIV: cnt <= cnt + 1'b1;
        default: cnt <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        if (start) begin
          x0  <= x_in;
          acc <= '0;
        end
      end
      L_MAC: begin
        prod <= PROD_W'(op_a) * PROD_W'(op_b);
        tag  <= cnt;
        acc  <= acc_next;
        if (pvalid && (tag == TERM_A1_HI || tag == TERM_A2_HI)) fb <= prod;
      end
      L_SAT: begin
        neg <= y_sat[Y_W-1];
        mag <= y_abs[Y_W-1:16];
        dvd <= y_abs[Y_W-1:16];
        rem <= '0;
        dsr <= (step == '0) ? STEP_W'(1) : step;
      end
      L_DIV: begin
        rem <= rem_next;
        dvd <= dvd_next;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/qbq_merge.sv
// ----------------------------------------------------------------------------
// qbq_merge: lane merge and output register
// Waits until every lane has finished and the output register is free,
// then loads all lane results into it as one beat and frees the lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module qbq_merge (
  input  logic               clk,
  input  logic               rst,
  input  qbq_pkg::lane_out_t lanes [qbq_pkg::LANES],
  input  logic               out_stall,
  output logic               out_valid,
  output qbq_pkg::sample_t   filtered [qbq_pkg::LANES],
  output logic               ack
);
  import qbq_pkg::*;

  logic all_done;

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < LANES; i++) all_done = all_done & lanes[i].done;
    ack = all_done && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ack) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      for (int i = 0; i < LANES; i++) filtered[i] <= lanes[i].result;
    end
  end

endmodule

`default_nettype wire

// File: hdl/quantized_biquad_six_lane_core.sv
// ----------------------------------------------------------------------------
// quantized_biquad_six_lane_core: six-lane quantized biquad filter
// Six parallel Direct Form I sections with shared coefficients, each output
// saturated and truncated to a multiple of its group's quantization step.
// ----------------------------------------------------------------------------
// Usage:
//   A beat on the input channel (in_valid high, in_stall low) carries one
//   Q16.16 sample per lane. Each lane multiplies its seven partial products
//   one per cycle on its own multiplier, followed by a drain step, then
//   saturates and quantizes with a 4-bit-per-cycle divider. A new vector is
//   accepted only once the merge stage has taken the previous results,
//   since the lane sequencer handles one vector at a time. in_stall stays
//   high from acceptance until the results move into the output register.
//   If the receiver holds out_stall, the result stays in the output register
//   and the lanes can still take and finish the next vector, which waits in
//   the lanes until the output register frees up.
//   Coefficients and steps are written through cfg_write/cfg_index/cfg_data
//   while the core is idle; writes to an unused index are ignored.
//   Reset is synchronous: it loads the default coefficients and steps and
//   clears all filter history and out_valid, but not the output data.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_biquad_six_lane_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] sample_0,
  input  logic signed [31:0] sample_1,
  input  logic signed [31:0] sample_2,
  input  logic signed [31:0] sample_3,
  input  logic signed [31:0] sample_4,
  input  logic signed [31:0] sample_5,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] filtered_0,
  output logic signed [31:0] filtered_1,
  output logic signed [31:0] filtered_2,
  output logic signed [31:0] filtered_3,
  output logic signed [31:0] filtered_4,
  output logic signed [31:0] filtered_5
);
  import qbq_pkg::*;

  coef_set_t coefs;
  step_t     step_first, step_second;
  logic      busy;
  logic      start;
  logic      lanes_ack;

  sample_t   samples  [LANES];
  sample_t   results  [LANES];
  step_t     lane_step [LANES];
  lane_out_t lane_status [LANES];

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;
  assign samples[4] = sample_4;
  assign samples[5] = sample_5;

  assign filtered_0 = results[0];
  assign filtered_1 = results[1];
  assign filtered_2 = results[2];
  assign filtered_3 = results[3];
  assign filtered_4 = results[4];
  assign filtered_5 = results[5];

  assign in_stall = busy;
  assign start    = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0    <= RST_B0;
      coefs.b1    <= RST_B1;
      coefs.b2    <= RST_B2;
      coefs.a1    <= RST_A1;
      coefs.a2    <= RST_A2;
      step_first  <= RST_STEP_FIRST;
      step_second <= RST_STEP_SECOND;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_B0:          coefs.b0    <= cfg_data;
        REG_B1:          coefs.b1    <= cfg_data;
        REG_B2:          coefs.b2    <= cfg_data;
        REG_A1:          coefs.a1    <= cfg_data;
        REG_A2:          coefs.a2    <= cfg_data;
        REG_STEP_FIRST:  step_first  <= cfg_data[STEP_W-1:0];
        REG_STEP_SECOND: step_second <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Busy from the accepted input beat until the merge stage takes the lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (lanes_ack) begin
      busy <= 1'b0;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i <= FIRST_GROUP_LAST) begin : g_first
      assign lane_step[i] = step_first;
    end else begin : g_second
      assign lane_step[i] = step_second;
    end

    qbq_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (start),
      .ack    (lanes_ack),
      .x_in   (samples[i]),
      .coefs  (coefs),
      .step   (lane_step[i]),
      .status (lane_status[i])
    );
  end

  qbq_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .lanes     (lane_status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .filtered  (results),
    .ack       (lanes_ack)
  );

endmodule

`default_nettype wire
